FILE: design/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, widths and codes of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	localparam int ADDR_W      = 20;                    // arena byte address
	localparam int BYTES_W     = 21;                    // block size register
	localparam int CNT_W       = 11;                    // block counts
	localparam int MAX_BLOCKS  = 1024;                  // link store depth
	localparam int IDX_W       = $clog2(MAX_BLOCKS);    // block index
	localparam int ARENA_BYTES = 1024 * 1024;
	localparam int SPAN_W      = BYTES_W + CNT_W;       // bytes * blocks
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_CNT_W   = $clog2(ADDR_W + 1);

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = BYTES_W;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_TOTAL = 2'd2;

	localparam logic KIND_ACQUIRE = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_EXHAUSTED = 2'd2,
		ST_NO_POOL   = 2'd3
	} status_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] block_address;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] granted_address;
		logic [CNT_W-1:0]  free_blocks;
		logic [CNT_W-1:0]  used_blocks;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  pool_base;
		logic [BYTES_W-1:0] block_bytes;
		logic [CNT_W-1:0]   block_total;
		logic               pool_ok;
	} cfg_t;

	// classified request, front to back
	typedef struct packed {
		logic             kind;
		logic             addr_ok;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_INIT,
		B_IDLE,
		B_ACQ,
		B_ADD
	} back_state_t;

endpackage

FILE: design/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/fbpa_queue.sv
// ----------------------------------------------------------------------------
// fbpa_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module fbpa_queue
	import fbpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic empty,
	output cmd_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule

FILE: design/fbpa_front.sv
// ----------------------------------------------------------------------------
// fbpa_front
// Takes requests and classifies them; a release address is checked for
// pool range and block alignment by a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module fbpa_front
	import fbpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  req_t req,
	input  cfg_t cfg,
	input  logic full,
	output logic busy,
	output logic push,
	output cmd_t push_cmd
);

	front_state_t         state_q, state_d;
	logic                 kind_q;
	logic                 ge_q;
	logic [ADDR_W-1:0]    quo_q;
	logic [BYTES_W-1:0]   rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [BYTES_W:0]     shifted;
	logic [BYTES_W+1:0]   diff;
	logic                 borrow;

	assign shifted = {rem_q, quo_q[ADDR_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, cfg.block_bytes};
	assign borrow  = diff[BYTES_W+1];

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (take) begin
					state_d = (req.kind == KIND_RELEASE) ? F_DIV : F_PUSH;
				end
			end
			F_DIV: begin
				if (cnt_q == DIV_CNT_W'(ADDR_W - 1)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		busy             = (state_q != F_IDLE);
		push             = (state_q == F_PUSH) && !full;
		push_cmd.kind    = kind_q;
		push_cmd.addr_ok = ge_q && (rem_q == '0) && (quo_q < ADDR_W'(cfg.block_total));
		push_cmd.idx     = quo_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// divider: dividend is the offset into the pool, one quotient bit a cycle
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (take) begin
					kind_q <= req.kind;
					ge_q   <= (req.block_address >= cfg.pool_base);
					quo_q  <= req.block_address - cfg.pool_base;
					rem_q  <= '0;
					cnt_q  <= '0;
				end
			end
			F_DIV: begin
				rem_q <= borrow ? shifted[BYTES_W-1:0] : diff[BYTES_W-1:0];
				quo_q <= {quo_q[ADDR_W-2:0], !borrow};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: design/fbpa_back.sv
// ----------------------------------------------------------------------------
// fbpa_back
// Owns the LIFO free list: link RAM, head and free count. Pops classified
// requests, updates the list and issues one result word per request.
// ----------------------------------------------------------------------------
module fbpa_back
	import fbpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic rebuild,
	input  cfg_t cfg,
	input  logic empty,
	input  cmd_t head,
	output logic pop,
	output logic init,
	output logic done,
	output rsp_t rsp
);

	back_state_t              state_q, state_d;
	logic [IDX_W-1:0]         init_cnt_q;
	logic [CNT_W-1:0]         head_q;
	logic [CNT_W-1:0]         free_q;
	logic [IDX_W-1:0]         gidx_q;
	logic [IDX_W+BYTES_W-1:0] prod_s1;
	logic                     done_q;
	rsp_t                     rsp_q;

	logic                     ram_we;
	logic [IDX_W-1:0]         ram_waddr;
	logic [CNT_W-1:0]         ram_wdata;
	logic                     ram_re;
	logic [CNT_W-1:0]         ram_rdata;

	logic                     init_last;
	logic                     go_acq;
	logic                     go_rel;
	logic                     emit;
	status_t                  emit_status;
	logic [ADDR_W-1:0]        emit_addr;
	logic [CNT_W-1:0]         emit_free;

	assign init_last = (init_cnt_q == IDX_W'(MAX_BLOCKS - 1));
	assign go_acq    = (state_q == B_IDLE) && !empty && cfg.pool_ok &&
	                   (head.kind == KIND_ACQUIRE) && (free_q != '0);
	assign go_rel    = (state_q == B_IDLE) && !empty && cfg.pool_ok &&
	                   (head.kind == KIND_RELEASE) && head.addr_ok &&
	                   (free_q < cfg.block_total);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_INIT: begin
				if (init_last) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (go_acq) begin
					state_d = B_ACQ;
				end
			end
			B_ACQ:   state_d = B_ADD;
			B_ADD:   state_d = B_IDLE;
			default: state_d = B_INIT;
		endcase
		if (rebuild) begin
			state_d = B_INIT;
		end
	end

	always_comb begin
		init        = (state_q == B_INIT);
		pop         = (state_q == B_IDLE) && !empty;
		ram_we      = 1'b0;
		ram_waddr   = init_cnt_q;
		ram_wdata   = CNT_W'(init_cnt_q) + 1'b1;
		ram_re      = go_acq;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_addr   = '0;
		emit_free   = free_q;
		case (state_q)
			B_INIT: begin
				ram_we = 1'b1;
			end
			B_IDLE: begin
				if (!empty) begin
					if (!cfg.pool_ok) begin
						emit        = 1'b1;
						emit_status = ST_NO_POOL;
						emit_free   = '0;
					end else if (head.kind == KIND_ACQUIRE) begin
						if (free_q == '0) begin
							emit        = 1'b1;
							emit_status = ST_EXHAUSTED;
						end
					end else if (go_rel) begin
						ram_we    = 1'b1;
						ram_waddr = head.idx;
						ram_wdata = head_q;
						emit      = 1'b1;
						emit_free = free_q + 1'b1;
					end else begin
						emit        = 1'b1;
						emit_status = ST_INVALID;
					end
				end
			end
			B_ADD: begin
				emit      = 1'b1;
				emit_addr = cfg.pool_base + prod_s1[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	fbpa_ram #(
		.WIDTH(CNT_W),
		.DEPTH(MAX_BLOCKS)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(head_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_INIT;
			init_cnt_q <= '0;
			head_q     <= '0;
			free_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (rebuild) begin
				init_cnt_q <= '0;
			end else begin
				case (state_q)
					B_INIT: begin
						init_cnt_q <= init_cnt_q + 1'b1;
						if (init_last) begin
							head_q <= '0;
							free_q <= cfg.block_total;
						end
					end
					B_IDLE: begin
						if (go_rel) begin
							head_q <= CNT_W'(head.idx);
							free_q <= free_q + 1'b1;
						end
					end
					B_ACQ: begin
						head_q <= ram_rdata;
						free_q <= free_q - 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_acq) begin
			gidx_q <= head_q[IDX_W-1:0];
		end
		if (state_q == B_ACQ) begin
			prod_s1 <= (IDX_W+BYTES_W)'(gidx_q) * (IDX_W+BYTES_W)'(cfg.block_bytes);
		end
		if (emit) begin
			rsp_q.status          <= emit_status;
			rsp_q.granted_address <= emit_addr;
			rsp_q.free_blocks     <= emit_free;
			rsp_q.used_blocks     <= (emit_status == ST_NO_POOL) ? '0
			                         : cfg.block_total - emit_free;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: design/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// One pool of equal blocks in a 1 MiB arena, served from a LIFO free list.
// ----------------------------------------------------------------------------
// A request word is taken at a clock edge with start high and busy low; its
// result word comes back on rsp with done high for exactly one cycle, and the
// receiver must take it then since there is no way to stall it. Results come
// in request order. An acquire goes from the take to the push into the queue,
// which waits while the queue is full; in the back it passes a link read, an
// index multiply and a base add before its result is registered on rsp, and
// the back pops no new request until that base add. A release stays in the
// front through the 20-step bit-serial divider that checks the address for
// pool range and block alignment, and the front takes no new request until
// it is pushed. After reset and after every write to a known register the
// link RAM is refilled in ascending order, one entry a cycle, over all 1024
// entries, with busy held high; the config port stays ready throughout and
// such a write restarts that pass.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
	import fbpa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// request / result
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output rsp_t                  rsp,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// config registers
	logic [ADDR_W-1:0]  pool_base_q;
	logic [BYTES_W-1:0] block_bytes_q;
	logic [CNT_W-1:0]   block_total_q;
	logic [SPAN_W-1:0]  span_q;      // block_bytes * block_total
	logic               pool_ok_q;   // nonzero pool within MAX_BLOCKS that fits the arena

	logic               rebuild;
	logic               take;
	logic               front_busy;
	logic               init;
	cfg_t               cfg;

	logic               push;
	cmd_t               push_cmd;
	logic               pop;
	logic               q_full;
	logic               q_empty;
	cmd_t               q_head;

	assign cfg_ready = 1'b1;

	// only writes to a known register rebuild the pool
	assign rebuild = cfg_valid && cfg_ready &&
	                 ((cfg_index == REG_POOL_BASE) || (cfg_index == REG_BLOCK_BYTES) ||
	                  (cfg_index == REG_BLOCK_TOTAL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= '0;
			block_bytes_q <= BYTES_W'(64);
			block_total_q <= CNT_W'(16);
			span_q        <= SPAN_W'(1024);
			pool_ok_q     <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_POOL_BASE:   pool_base_q   <= cfg_data[ADDR_W-1:0];
					REG_BLOCK_BYTES: block_bytes_q <= cfg_data[BYTES_W-1:0];
					REG_BLOCK_TOTAL: block_total_q <= cfg_data[CNT_W-1:0];
					default: begin
					end
				endcase
			end
			// fit check is two registered steps; the refill pass hides it
			span_q    <= SPAN_W'(block_bytes_q) * SPAN_W'(block_total_q);
			pool_ok_q <= (block_bytes_q != '0) && (block_total_q != '0) &&
			             (block_total_q <= CNT_W'(MAX_BLOCKS)) &&
			             (span_q <= SPAN_W'(ARENA_BYTES) - SPAN_W'(pool_base_q));
		end
	end

	assign cfg.pool_base   = pool_base_q;
	assign cfg.block_bytes = block_bytes_q;
	assign cfg.block_total = block_total_q;
	assign cfg.pool_ok     = pool_ok_q;

	assign busy = front_busy || init;
	assign take = start && !busy;

	// front: accept and classify
	fbpa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.req     (req),
		.cfg     (cfg),
		.full    (q_full),
		.busy    (front_busy),
		.push    (push),
		.push_cmd(push_cmd)
	);

	// decoupling queue
	fbpa_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.head    (q_head)
	);

	// back: free list and results
	fbpa_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rebuild(rebuild),
		.cfg    (cfg),
		.empty  (q_empty),
		.head   (q_head),
		.pop    (pop),
		.init   (init),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

FILE: tb/sv/fixed_block_pool_allocator_tb.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_tb
// Self-checking bench for the fixed block pool allocator.
// ----------------------------------------------------------------------------
// A behavioral copy of the free list (links, head, free count, pool-ok flag)
// follows every accepted config write and request word and predicts each
// result word. Results are compared field by field, in order, as they come
// back on the done strobe. A short directed table goes first: the reset pool,
// the all-free release, LIFO reuse, bad addresses, exhaustion, pools that do
// not fit, and the largest blocks and counts. Random phases follow, each with
// its own pool geometry and request mix. Most words in a phase acquire or
// hand back blocks that are really out, so the list gets deep and empty; the
// rest are grid and noise releases.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;
	import fbpa_pkg::*;

	// index 3 is not a register; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RAND_ITEMS   = 800;
	localparam int TAIL_CYCLES  = 40;          // idle wait after the last result
	localparam int RUN_LIMIT    = 20_000_000;  // watchdog time limit, far past a clean run

	typedef struct {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		req_t                  word;
		logic                  pinned;   // want holds a typed-in result
		rsp_t                  want;
	} tab_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	req_t                  req;
	logic                  done;
	rsp_t                  rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// typed-in result travelling with the request word
	logic                  pin_on;
	rsp_t                  pin_want;

	// shadow pool
	logic [ADDR_W-1:0]     cfg_base;
	logic [BYTES_W-1:0]    cfg_bytes;
	logic [CNT_W-1:0]      cfg_total;
	logic                  pool_up;
	logic [CNT_W-1:0]      link_mem [MAX_BLOCKS];
	logic [CNT_W-1:0]      head_blk;
	logic [CNT_W-1:0]      free_cnt;

	rsp_t                  rsp_pending [$];   // results owed by the block, oldest first
	logic [ADDR_W-1:0]     held_addr [$];     // blocks handed out, for sane releases
	int                    err_cnt;

	tab_row_t              dir_tab [$];
	int                    acq_pct;
	logic                  calm;              // phase with no sender gaps

	fixed_block_pool_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// shadow pool
	// ------------------------------------------------------------------

	// every register write refills the list in ascending order
	task automatic rebuild_pool();
		longint unsigned span;
		longint unsigned room;
		span = longint'(cfg_bytes) * longint'(cfg_total);
		room = 64'(ARENA_BYTES) - 64'(cfg_base);
		pool_up = (cfg_bytes != 0) && (cfg_total != 0) &&
			(cfg_total <= CNT_W'(MAX_BLOCKS)) && (span <= room);
		for (int i = 0; i < MAX_BLOCKS; i++)
			link_mem[i] = CNT_W'(i + 1);
		head_blk = '0;
		free_cnt = pool_up ? cfg_total : '0;
	endtask

	task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_POOL_BASE: begin
				cfg_base = data[ADDR_W-1:0];
			end
			REG_BLOCK_BYTES: begin
				cfg_bytes = data[BYTES_W-1:0];
			end
			REG_BLOCK_TOTAL: begin
				cfg_total = data[CNT_W-1:0];
			end
			default: begin
				return;
			end
		endcase
		rebuild_pool();
	endtask

	task automatic alloc_predict(input req_t w, output rsp_t r);
		logic [IDX_W-1:0] slot;
		longint unsigned  a64;
		longint unsigned  off;
		longint unsigned  blk;
		logic             addr_ok;
		r = '0;
		r.status = ST_OK;
		if (!pool_up) begin
			r.status = ST_NO_POOL;
			return;
		end
		if (w.kind == KIND_ACQUIRE) begin
			if (free_cnt == 0) begin
				r.status = ST_EXHAUSTED;
			end else begin
				slot = head_blk[IDX_W-1:0];
				a64 = 64'(cfg_base) + 64'(slot) * 64'(cfg_bytes);
				r.granted_address = a64[ADDR_W-1:0];
				head_blk = link_mem[slot];
				free_cnt = free_cnt - 1'b1;
			end
		end else begin
			addr_ok = 1'b0;
			blk = 0;
			a64 = 64'(w.block_address);
			if (a64 >= 64'(cfg_base)) begin
				off = a64 - 64'(cfg_base);
				blk = off / 64'(cfg_bytes);
				addr_ok = (off % 64'(cfg_bytes) == 0) && (blk < 64'(cfg_total));
			end
			// a release with every block already free is refused
			if (!addr_ok || free_cnt >= cfg_total) begin
				r.status = ST_INVALID;
			end else begin
				slot = blk[IDX_W-1:0];
				link_mem[slot] = head_blk;
				head_blk = CNT_W'(slot);
				free_cnt = free_cnt + 1'b1;
			end
		end
		r.free_blocks = free_cnt;
		r.used_blocks = cfg_total - free_cnt;
	endtask

	// ------------------------------------------------------------------
	// scoreboard: compare the oldest owed result, then take in the edge's
	// config write or request word
	// ------------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		rsp_t want;
		rsp_t calc;
		int   k;
		if (!arst_n) begin
			cfg_base  = '0;
			cfg_bytes = BYTES_W'(64);
			cfg_total = CNT_W'(16);
			rebuild_pool();
			held_addr.delete();
		end else begin
			if (done) begin
				if (rsp_pending.size() == 0) begin
					$error("result word with no request outstanding");
					err_cnt++;
				end else begin
					want = rsp_pending.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						err_cnt++;
					end
					if (rsp.granted_address !== want.granted_address) begin
						$error("granted_address: expected 0x%05h, actual 0x%05h",
							want.granted_address, rsp.granted_address);
						err_cnt++;
					end
					if (rsp.free_blocks !== want.free_blocks) begin
						$error("free_blocks: expected %0d, actual %0d",
							want.free_blocks, rsp.free_blocks);
						err_cnt++;
					end
					if (rsp.used_blocks !== want.used_blocks) begin
						$error("used_blocks: expected %0d, actual %0d",
							want.used_blocks, rsp.used_blocks);
						err_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				apply_cfg(cfg_index, cfg_data);
				held_addr.delete();
			end
			if (start && !busy) begin
				alloc_predict(req, calc);
				rsp_pending.push_back(pin_on ? pin_want : calc);
				// keep track of what is out so the stimulus can hand it back
				if (calc.status == ST_OK) begin
					if (req.kind == KIND_ACQUIRE) begin
						held_addr.push_back(calc.granted_address);
					end else begin
						for (k = 0; k < held_addr.size(); k++) begin
							if (held_addr[k] == req.block_address) begin
								held_addr.delete(k);
								break;
							end
						end
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// start stays high on return; the caller lowers it or sends the next word
	task automatic push_word(input req_t w, input logic pinned, input rsp_t want);
		start    <= 1'b1;
		req      <= w;
		pin_on   <= pinned;
		pin_want <= want;
		do @(posedge clk); while (busy);
	endtask

	// cfg_valid stays high on return, same reasoning as push_word
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// mostly back to back or short, now and then a long pause
	task automatic idle_gap();
		int unsigned r;
		int unsigned n;
		r = $urandom_range(0, 99);
		if (calc_gap_off())
			n = 0;
		else if (r < 60)
			n = 0;
		else if (r < 95)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(20, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic calc_gap_off();
		return calm;
	endfunction

	// lower start and wait out every owed result (each word has one)
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (rsp_pending.size() != 0);
	endtask

	// random word: acquire, release of a block that is out, grid release
	// (may be a double release) or pure noise
	task automatic rand_word(output req_t w);
		int unsigned     r;
		longint unsigned a64;
		r = $urandom_range(0, 99);
		w.kind = KIND_ACQUIRE;
		w.block_address = ADDR_W'($urandom);
		if (r < acq_pct || (r < 80 && held_addr.size() == 0)) begin
			w.kind = KIND_ACQUIRE;
		end else if (r < 80) begin
			w.kind = KIND_RELEASE;
			w.block_address = held_addr[$urandom_range(0, held_addr.size() - 1)];
		end else if (r < 90) begin
			w.kind = KIND_RELEASE;
			a64 = 64'(cfg_base) + 64'($urandom_range(0, (cfg_total == 0) ? 0 : cfg_total - 1))
				* 64'(cfg_bytes);
			w.block_address = a64[ADDR_W-1:0];
		end else begin
			w.kind = KIND_RELEASE;
		end
	endtask

	// geometry of one random phase; a fifth of the phases get a pool that
	// cannot be built and only a handful of words
	task automatic plan_phase(output logic [ADDR_W-1:0] base, output logic [BYTES_W-1:0] bytes,
		output logic [CNT_W-1:0] total, output int n);
		int unsigned     sel;
		longint unsigned span;
		longint unsigned top;
		sel = $urandom_range(0, 9);
		n = $urandom_range(40, 120);
		base = ADDR_W'($urandom);
		case (sel)
			0, 1, 2: begin
				total = CNT_W'($urandom_range(1, 4));
				bytes = BYTES_W'($urandom_range(1, 64));
			end
			3, 4: begin
				total = CNT_W'($urandom_range(5, 48));
				bytes = BYTES_W'($urandom_range(1, 8192));
			end
			5: begin
				total = CNT_W'(MAX_BLOCKS);
				bytes = BYTES_W'($urandom_range(1, 1024));
			end
			6, 7: begin
				total = CNT_W'($urandom_range(1, 4));
				bytes = BYTES_W'($urandom_range(1, ARENA_BYTES / total));
			end
			default: begin
				n = 8;
				case ($urandom_range(0, 3))
					0: begin
						total = CNT_W'($urandom_range(MAX_BLOCKS + 1, 2047));
						bytes = BYTES_W'(64);
					end
					1: begin
						total = CNT_W'(16);
						bytes = '0;
					end
					2: begin
						total = '0;
						bytes = BYTES_W'(64);
					end
					default: begin
						// full arena span, any nonzero base runs off the end
						total = CNT_W'(MAX_BLOCKS);
						bytes = BYTES_W'(1024);
						base = ADDR_W'($urandom_range(1, 20'hFFFFF));
					end
				endcase
			end
		endcase
		if (sel < 8) begin
			span = 64'(bytes) * 64'(total);
			top = 64'(ARENA_BYTES) - span;
			if (top > 64'h0FFFFF)
				top = 64'h0FFFFF;
			// pin the pool against the top of the arena now and then
			base = ($urandom_range(0, 4) == 0) ? ADDR_W'(top) : ADDR_W'($urandom_range(0, top));
		end
	endtask

	// ------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------
	function automatic tab_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		tab_row_t t;
		t = '{default: '0};
		t.is_cfg = 1'b1;
		t.idx = idx;
		t.data = data;
		return t;
	endfunction

	function automatic tab_row_t req_row(input logic kind, input logic [ADDR_W-1:0] addr,
		input status_t st, input logic [ADDR_W-1:0] g, input int f, input int u);
		tab_row_t t;
		t = '{default: '0};
		t.word.kind = kind;
		t.word.block_address = addr;
		t.pinned = 1'b1;
		t.want.status = st;
		t.want.granted_address = g;
		t.want.free_blocks = CNT_W'(f);
		t.want.used_blocks = CNT_W'(u);
		return t;
	endfunction

	// result left to the shadow pool
	function automatic tab_row_t plain_row(input logic kind, input logic [ADDR_W-1:0] addr);
		tab_row_t t;
		t = '{default: '0};
		t.word.kind = kind;
		t.word.block_address = addr;
		return t;
	endfunction

	task automatic fill_table();
		// reset pool: base 0, 64-byte blocks, 16 of them
		dir_tab.push_back(req_row(KIND_RELEASE, 20'h00000, ST_INVALID, 0, 16, 0)); // all free
		dir_tab.push_back(req_row(KIND_ACQUIRE, 20'h00000, ST_OK, 20'h00000, 15, 1));
		dir_tab.push_back(req_row(KIND_ACQUIRE, 20'h00000, ST_OK, 20'h00040, 14, 2));
		dir_tab.push_back(plain_row(KIND_RELEASE, 20'h00040));
		dir_tab.push_back(plain_row(KIND_ACQUIRE, 20'h00000));                     // LIFO reuse
		dir_tab.push_back(cfg_row(REG_UNUSED, 21'h1FFFFF));                         // no effect
		dir_tab.push_back(req_row(KIND_RELEASE, 20'h00020, ST_INVALID, 0, 14, 2)); // misaligned
		dir_tab.push_back(req_row(KIND_RELEASE, 20'h00400, ST_INVALID, 0, 14, 2)); // at end
		dir_tab.push_back(req_row(KIND_RELEASE, 20'hFFFFF, ST_INVALID, 0, 14, 2));
		dir_tab.push_back(plain_row(KIND_RELEASE, 20'h003C0));                     // never out
		dir_tab.push_back(plain_row(KIND_ACQUIRE, 20'hFFFFF));                     // addr ignored
		// single block: exhaust it and give it back
		dir_tab.push_back(cfg_row(REG_BLOCK_TOTAL, 21'd1));
		dir_tab.push_back(req_row(KIND_ACQUIRE, 20'h00000, ST_OK, 20'h00000, 0, 1));
		dir_tab.push_back(req_row(KIND_ACQUIRE, 20'h00000, ST_EXHAUSTED, 0, 0, 1));
		dir_tab.push_back(req_row(KIND_RELEASE, 20'h00000, ST_OK, 0, 1, 0));
		// top of the arena: 64 bytes do not fit, one byte does
		dir_tab.push_back(cfg_row(REG_POOL_BASE, 21'h0FFFFF));
		dir_tab.push_back(req_row(KIND_ACQUIRE, 20'h00000, ST_NO_POOL, 0, 0, 0));
		dir_tab.push_back(cfg_row(REG_BLOCK_BYTES, 21'd1));
		dir_tab.push_back(req_row(KIND_RELEASE, 20'hFFFFF, ST_INVALID, 0, 1, 0));
		dir_tab.push_back(req_row(KIND_ACQUIRE, 20'h00000, ST_OK, 20'hFFFFF, 0, 1));
		dir_tab.push_back(req_row(KIND_RELEASE, 20'hFFFFE, ST_INVALID, 0, 0, 1)); // below base
		dir_tab.push_back(req_row(KIND_RELEASE, 20'hFFFFF, ST_OK, 0, 1, 0));
		// one block the size of the arena
		dir_tab.push_back(cfg_row(REG_POOL_BASE, 21'd0));
		dir_tab.push_back(cfg_row(REG_BLOCK_BYTES, 21'h100000));
		dir_tab.push_back(req_row(KIND_ACQUIRE, 20'h00000, ST_OK, 20'h00000, 0, 1));
		dir_tab.push_back(req_row(KIND_RELEASE, 20'h00000, ST_OK, 0, 1, 0));
		// most blocks, filling the arena exactly
		dir_tab.push_back(cfg_row(REG_BLOCK_BYTES, 21'd1024));
		dir_tab.push_back(cfg_row(REG_BLOCK_TOTAL, 21'd1024));
		dir_tab.push_back(req_row(KIND_ACQUIRE, 20'h00000, ST_OK, 20'h00000, 1023, 1));
		dir_tab.push_back(req_row(KIND_RELEASE, 20'hFFC00, ST_OK, 0, 1024, 0));
		// counts and sizes the pool cannot be built from
		dir_tab.push_back(cfg_row(REG_BLOCK_TOTAL, 21'd1025));
		dir_tab.push_back(req_row(KIND_RELEASE, 20'h00000, ST_NO_POOL, 0, 0, 0));
		dir_tab.push_back(cfg_row(REG_BLOCK_TOTAL, 21'd0));
		dir_tab.push_back(req_row(KIND_ACQUIRE, 20'h00000, ST_NO_POOL, 0, 0, 0));
		dir_tab.push_back(cfg_row(REG_BLOCK_BYTES, 21'd0));
		dir_tab.push_back(cfg_row(REG_BLOCK_TOTAL, 21'd16));
		dir_tab.push_back(req_row(KIND_ACQUIRE, 20'h00000, ST_NO_POOL, 0, 0, 0));
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		req_t              w;
		rsp_t              none;
		logic [ADDR_W-1:0] base;
		logic [BYTES_W-1:0] bytes;
		logic [CNT_W-1:0]  total;
		int                n;
		int                rand_cnt;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		req       <= '0;
		pin_on    <= 1'b0;
		pin_want  <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		err_cnt = 0;
		acq_pct = 45;
		calm = 1'b0;
		none = '0;
		rand_cnt = 0;
		fill_table();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the refill after reset shows up as busy, push_word waits it out
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				drain();
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			end else begin
				cfg_valid <= 1'b0;
				push_word(dir_tab[i].word, dir_tab[i].pinned, dir_tab[i].want);
				idle_gap();
			end
		end

		while (rand_cnt < RAND_ITEMS) begin
			plan_phase(base, bytes, total, n);
			drain();
			write_reg(REG_POOL_BASE, CFG_DATA_W'(base));
			write_reg(REG_BLOCK_BYTES, CFG_DATA_W'(bytes));
			write_reg(REG_BLOCK_TOTAL, CFG_DATA_W'(total));
			cfg_valid <= 1'b0;
			case ($urandom_range(0, 2))
				0: acq_pct = 30;
				1: acq_pct = 50;
				default: acq_pct = 70;
			endcase
			calm = ($urandom_range(0, 3) == 0);
			repeat (n) begin
				rand_word(w);
				push_word(w, 1'b0, none);
				rand_cnt++;
				idle_gap();
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (rsp_pending.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && rsp_pending.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// hang guard: a lost result word stalls the drain loops above
	initial begin : watchdog
		#(RUN_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: fixed_block_pool_allocator.f
design/fbpa_pkg.sv
design/fbpa_ram.sv
design/fbpa_queue.sv
design/fbpa_front.sv
design/fbpa_back.sv
design/fixed_block_pool_allocator.sv
tb/sv/fixed_block_pool_allocator_tb.sv
